// ===== hw/rtl/lcps_pkg.sv =====
// Shared types, constants and the frame buffer address function for the
// LED cube plane scan driver. No dependencies.
`default_nettype none

package lcps_pkg;

    // Cube geometry and frame buffer size
    localparam int CUBE_EDGE  = 4;
    localparam int NUM_COLORS = 3;
    localparam int FB_DEPTH   = CUBE_EDGE * CUBE_EDGE * CUBE_EDGE * NUM_COLORS;
    localparam int FB_AW      = $clog2(FB_DEPTH);

    // Operation codes
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CMD   = 2'd2;

    // Color codes
    localparam logic [1:0] COLOR_RED  = 2'd0;
    localparam logic [1:0] COLOR_BLUE = 2'd2;
    localparam logic [1:0] COLOR_NONE = 2'd3;

    // Word framing
    localparam logic [3:0] LAST_WORD         = 4'd15;
    localparam logic [4:0] NO_LATCH          = 5'd16;
    localparam logic [4:0] GLOBAL_LATCH_BIT  = 5'd14;
    localparam logic [4:0] COMMAND_LATCH_BIT = 5'd6;

    // Command word travels in digits of DIGIT_W bits
    localparam int DIGIT_W    = 4;
    localparam int CMD_DIGITS = 16 / DIGIT_W;
    localparam int DIGIT_CW   = $clog2(CMD_DIGITS);

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  pos_x;
        logic [1:0]  pos_y;
        logic [1:0]  pos_z;
        logic [1:0]  color_plane;
        logic [7:0]  intensity;
        logic [15:0] command_word;
    } in_item_t;

    typedef struct packed {
        logic [15:0] shift_data;
        logic [4:0]  latch_from_bit;
        logic        extra_latch_clock;
        logic        row_update;
        logic [3:0]  row_select;
        logic        last;
    } out_item_t;

    // Frame buffer write port
    typedef struct packed {
        logic             en;
        logic [FB_AW-1:0] addr;
        logic [7:0]       data;
    } fb_wr_t;

    // Frame buffer read request
    typedef struct packed {
        logic             en;
        logic [FB_AW-1:0] addr;
    } fb_rd_req_t;

    // Start request from the input decode to the sequencer
    typedef struct packed {
        logic        tick;
        logic        cmd;
        logic [15:0] cmd_word;
    } seq_start_t;

    // Entry index ((x*4 + y)*4 + z)*3 + c
    function automatic logic [FB_AW-1:0] fb_addr(input logic [1:0] x, input logic [1:0] y,
                                                 input logic [1:0] z, input logic [1:0] c);
        logic [5:0] n;
        n = {x, y, z};
        return {1'b0, n, 1'b0} + {2'b00, n} + {6'b000000, c};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcps_frame_mem.sv =====
// Frame buffer memory with per-entry valid bits; unwritten entries read zero.
// Depends on lcps_pkg.
`default_nettype none

module lcps_frame_mem (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lcps_pkg::fb_wr_t    wr,
    input  wire lcps_pkg::fb_rd_req_t rd,
    output logic [7:0]              rd_byte
);

    logic [7:0]                  mem [lcps_pkg::FB_DEPTH];
    logic [lcps_pkg::FB_DEPTH-1:0] vld_reg;
    logic [7:0]                  data_reg;
    logic                        hit_reg;

    // Write and registered read of the storage array
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            data_reg <= mem[rd.addr];
        end
    end

    // Track written entries; reset clears them all at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                hit_reg <= vld_reg[rd.addr];
            end
        end
    end

    assign rd_byte = hit_reg ? data_reg : 8'h00;

endmodule

`default_nettype wire

// ===== hw/rtl/lcps_scan_seq.sv =====
// Scan sequencer: refresh and command words through a read stage and an
// output register; command words are assembled one digit per cycle.
// Depends on lcps_pkg.
`default_nettype none

module lcps_scan_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lcps_pkg::seq_start_t  start,
    output logic                      ready,
    output lcps_pkg::fb_rd_req_t       rd_req,
    input  wire logic [7:0]           rd_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output lcps_pkg::out_item_t        m_item
);

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_SCAN      = 4'b0010,
        ST_CMD_SHIFT = 4'b0100,
        ST_CMD_ISSUE = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [3:0]                   ch_reg, ch_next;
    logic [lcps_pkg::DIGIT_CW-1:0] digit_reg, digit_next;
    logic [15:0]                  cmd_sh_reg, cmd_sh_next;
    logic [15:0]                  asm_reg, asm_next;
    logic [1:0]                   color_reg, color_next;
    logic [1:0]                   plane_reg, plane_next;
    logic [3:0]                   dec_reg, dec_next;
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_cmd_reg, s1_cmd_next;
    logic [3:0]                   s1_ch_reg, s1_ch_next;
    logic                         m_valid_reg, m_valid_next;
    lcps_pkg::out_item_t           m_item_reg, m_item_next;

    logic       out_free;
    logic       s1_free;
    logic       issue_scan;
    logic       issue_cmd;
    logic       scan_last;
    logic       ld_last_scan;
    logic [3:0] new_sel;

    assign out_free   = !m_valid_reg || m_ready;
    assign s1_free    = !s1_valid_reg || out_free;
    assign issue_scan = (state_reg == ST_SCAN) && s1_free;
    assign issue_cmd  = (state_reg == ST_CMD_ISSUE) && s1_free;
    assign scan_last  = !s1_cmd_reg && (s1_ch_reg == lcps_pkg::LAST_WORD);
    assign ld_last_scan = out_free && s1_valid_reg && scan_last;
    assign new_sel    = {1'b0, plane_reg, 1'b0} + {2'b00, plane_reg} + {2'b00, color_reg};

    // Accept new work only with the read stage empty
    assign ready = (state_reg == ST_IDLE) && !s1_valid_reg;

    // Read the entry for channel ch: x = ch[1:0], y = ch[3:2]
    assign rd_req.en   = issue_scan;
    assign rd_req.addr = lcps_pkg::fb_addr(ch_reg[1:0], ch_reg[3:2], plane_reg, color_reg);

    // Sequence control, scan position and digit assembly
    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        digit_next  = digit_reg;
        cmd_sh_next = cmd_sh_reg;
        asm_next    = asm_reg;
        color_next  = color_reg;
        plane_next  = plane_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start.tick) begin
                    // Advance color; after blue wrap to red and step the plane
                    if (color_reg == lcps_pkg::COLOR_BLUE) begin
                        color_next = lcps_pkg::COLOR_RED;
                        plane_next = plane_reg + 2'd1;
                    end else begin
                        color_next = color_reg + 2'd1;
                    end
                    ch_next    = 4'd0;
                    state_next = ST_SCAN;
                end else if (start.cmd) begin
                    cmd_sh_next = start.cmd_word;
                    digit_next  = '0;
                    state_next  = ST_CMD_SHIFT;
                end
            end
            ST_SCAN: begin
                if (issue_scan) begin
                    ch_next = ch_reg + 4'd1;
                    if (ch_reg == lcps_pkg::LAST_WORD) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CMD_SHIFT: begin
                // Move one digit, MSB first, into the word assembler
                cmd_sh_next = {cmd_sh_reg[15-lcps_pkg::DIGIT_W:0], {lcps_pkg::DIGIT_W{1'b0}}};
                asm_next    = {asm_reg[15-lcps_pkg::DIGIT_W:0],
                               cmd_sh_reg[15:16-lcps_pkg::DIGIT_W]};
                digit_next  = digit_reg + 1'b1;
                if (digit_reg == lcps_pkg::DIGIT_CW'(lcps_pkg::CMD_DIGITS - 1)) begin
                    state_next = ST_CMD_ISSUE;
                end
            end
            ST_CMD_ISSUE: begin
                if (issue_cmd) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read stage and output register
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_cmd_next   = s1_cmd_reg;
        s1_ch_next    = s1_ch_reg;
        m_valid_next  = m_valid_reg;
        m_item_next   = m_item_reg;
        dec_next      = dec_reg;
        if (out_free) begin
            m_valid_next = s1_valid_reg;
            if (s1_valid_reg) begin
                if (s1_cmd_reg) begin
                    m_item_next.shift_data        = asm_reg;
                    m_item_next.latch_from_bit    = lcps_pkg::COMMAND_LATCH_BIT;
                    m_item_next.extra_latch_clock = 1'b0;
                    m_item_next.row_update        = 1'b0;
                    m_item_next.row_select        = dec_reg;
                    m_item_next.last              = 1'b1;
                end else begin
                    m_item_next.shift_data        = {rd_byte, 8'h00};
                    m_item_next.latch_from_bit    = scan_last ? lcps_pkg::GLOBAL_LATCH_BIT
                                                              : lcps_pkg::NO_LATCH;
                    m_item_next.extra_latch_clock = !scan_last;
                    m_item_next.row_update        = scan_last;
                    m_item_next.row_select        = scan_last ? new_sel : dec_reg;
                    m_item_next.last              = scan_last;
                    if (scan_last) begin
                        dec_next = new_sel;
                    end
                end
            end
            s1_valid_next = 1'b0;
        end
        if (issue_scan || issue_cmd) begin
            s1_valid_next = 1'b1;
            s1_cmd_next   = issue_cmd;
            s1_ch_next    = ch_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            color_reg    <= lcps_pkg::COLOR_RED;
            plane_reg    <= 2'd0;
            dec_reg      <= 4'd0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            ch_reg       <= 4'd0;
            digit_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            color_reg    <= color_next;
            plane_reg    <= plane_next;
            dec_reg      <= dec_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            ch_reg       <= ch_next;
            digit_reg    <= digit_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_sh_reg <= cmd_sh_next;
        asm_reg    <= asm_next;
        s1_cmd_reg <= s1_cmd_next;
        s1_ch_reg  <= s1_ch_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A tick starts the scan at channel zero
    a_tick_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (start.tick && ready) |=> (state_reg == ST_SCAN) && (ch_reg == 4'd0))
        else $error("scan did not start at channel zero");

    // A command word is ready to issue after all its digits
    a_cmd_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (start.cmd && !start.tick && ready) |=> ##4 (state_reg == ST_CMD_ISSUE))
        else $error("command digit assembly took the wrong number of cycles");

    // Decoder select moves only with the last scan word
    a_dec_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_reg != $past(dec_reg)) |-> $past(ld_last_scan))
        else $error("decoder select changed outside the last scan word");

    // A stalled read stage holds its word
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_ch_reg)
                                          && $stable(s1_cmd_reg)))
        else $error("read stage overwritten while stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/led_cube_plane_scan_driver.sv =====
// LED cube plane scan driver, top level.
//
// Input channel (s_valid/s_ready/s_item) takes one operation per beat:
//   pixel write  - stores one intensity in the frame buffer, gives no beat out;
//                  a write with color COLOR_NONE is dropped.
//   refresh tick - advances color (and plane after blue), then sends sixteen
//                  channel words, one per cycle while m_ready stays high. Each
//                  word is read through the frame buffer read register into the
//                  output register; the next item is taken once the last word
//                  has left the read stage.
//   command      - the command word moves four bits at a time through a shifter
//                  into the word assembler, then the read stage and the output
//                  register; the next item is taken with the read stage empty.
// Output channel (m_valid/m_ready/m_item) has an output register; a stalled
// receiver holds the pipeline and backs up to s_ready. A finished word may
// wait in the output register while the next item is accepted.
// Reset (aresetn, synchronous, active low) clears the scan position, the
// decoder select and all frame buffer valid bits at once, so every intensity
// reads zero right after reset; no clearing pass is needed.
// Depends on lcps_pkg, lcps_frame_mem and lcps_scan_seq.
`default_nettype none

module led_cube_plane_scan_driver (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lcps_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lcps_pkg::out_item_t      m_item
);

    logic                  in_acc;
    lcps_pkg::fb_wr_t       wr;
    lcps_pkg::fb_rd_req_t   rd_req;
    logic [7:0]            rd_byte;
    lcps_pkg::seq_start_t   start;

    assign in_acc = s_valid && s_ready;

    // Decode the accepted beat; drop pixel writes with no valid color
    always_comb begin
        wr.en   = in_acc && (s_item.operation == lcps_pkg::OP_PIXEL)
                         && (s_item.color_plane != lcps_pkg::COLOR_NONE);
        wr.addr = lcps_pkg::fb_addr(s_item.pos_x, s_item.pos_y, s_item.pos_z,
                                    s_item.color_plane);
        wr.data = s_item.intensity;
        start.tick     = in_acc && (s_item.operation == lcps_pkg::OP_TICK);
        start.cmd      = in_acc && (s_item.operation == lcps_pkg::OP_CMD);
        start.cmd_word = s_item.command_word;
    end

    lcps_frame_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd      (rd_req),
        .rd_byte (rd_byte)
    );

    lcps_scan_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .ready   (s_ready),
        .rd_req  (rd_req),
        .rd_byte (rd_byte),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire
